// ===== hdl/lpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

	// string capacity and derived widths
	localparam int unsigned MAX_LEN = 8;
	localparam int unsigned IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned UPC_W   = 5;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_EMIT  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [CHAR_W-1:0] char_in;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last_char;
		logic              final_arrangement;
	} rsp_t;

	// datapath operations of one control word
	typedef enum logic [4:0] {
		U_NOP,
		U_CLEAR,
		U_LD_INIT,
		U_LD_SHIFT,
		U_LD_PUT,
		U_EM_INIT,
		U_SAVE_B,
		U_DEC_A,
		U_PIV_TEST,
		U_OUT_INIT,
		U_EMIT,
		U_ADV_INIT,
		U_SCAN_B,
		U_SWAP_P,
		U_SWAP_J,
		U_SAVE_A,
		U_WR_A,
		U_WR_B_STEP
	} uop_t;

	// branch conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_JUMP,
		C_FULL,
		C_A_ZERO,
		C_A_NZ,
		C_CH_GT,
		C_LEN_ZERO,
		C_RD_LT_B,
		C_A_NLAST,
		C_FIN,
		C_RD_LE_A,
		C_A_GE_B
	} cond_t;

	// position store read address source
	typedef enum logic [1:0] {
		RA_NONE,
		RA_A,
		RA_B
	} pos_ra_t;

	// character store read address source
	typedef enum logic [1:0] {
		CA_NONE,
		CA_AM1,
		CA_POS
	} ch_ra_t;

	typedef struct packed {
		uop_t             op;
		pos_ra_t          pos_ra;
		ch_ra_t           ch_ra;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	// program step addresses
	localparam logic [UPC_W-1:0] S_IDLE = 5'd0;
	localparam logic [UPC_W-1:0] S_CLR  = 5'd1;
	localparam logic [UPC_W-1:0] S_L0   = 5'd2;
	localparam logic [UPC_W-1:0] S_L1   = 5'd3;
	localparam logic [UPC_W-1:0] S_L2   = 5'd4;
	localparam logic [UPC_W-1:0] S_L3   = 5'd5;
	localparam logic [UPC_W-1:0] S_E0   = 5'd6;
	localparam logic [UPC_W-1:0] S_E1   = 5'd7;
	localparam logic [UPC_W-1:0] S_E2   = 5'd8;
	localparam logic [UPC_W-1:0] S_E3   = 5'd9;
	localparam logic [UPC_W-1:0] S_E4   = 5'd10;
	localparam logic [UPC_W-1:0] S_E5   = 5'd11;
	localparam logic [UPC_W-1:0] S_E6   = 5'd12;
	localparam logic [UPC_W-1:0] S_O0   = 5'd13;
	localparam logic [UPC_W-1:0] S_O1   = 5'd14;
	localparam logic [UPC_W-1:0] S_O2   = 5'd15;
	localparam logic [UPC_W-1:0] S_O3   = 5'd16;
	localparam logic [UPC_W-1:0] S_A0   = 5'd17;
	localparam logic [UPC_W-1:0] S_A1   = 5'd18;
	localparam logic [UPC_W-1:0] S_A2   = 5'd19;
	localparam logic [UPC_W-1:0] S_A3   = 5'd20;
	localparam logic [UPC_W-1:0] S_A4   = 5'd21;
	localparam logic [UPC_W-1:0] S_R0   = 5'd22;
	localparam logic [UPC_W-1:0] S_R1   = 5'd23;
	localparam logic [UPC_W-1:0] S_R2   = 5'd24;
	localparam logic [UPC_W-1:0] S_R3   = 5'd25;
	localparam logic [UPC_W-1:0] S_R4   = 5'd26;

	function automatic ucode_t uw(input uop_t op, input pos_ra_t pra, input ch_ra_t cra,
			input cond_t cond, input logic [UPC_W-1:0] tgt);
		ucode_t w;
		w.op     = op;
		w.pos_ra = pra;
		w.ch_ra  = cra;
		w.cond   = cond;
		w.target = tgt;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
		ucode_t w;
		case (pc)
			// clear
			S_CLR:  w = uw(U_CLEAR,     RA_NONE, CA_NONE, C_JUMP,     S_IDLE);
			// sorted insert of one character
			S_L0:   w = uw(U_LD_INIT,   RA_NONE, CA_NONE, C_FULL,     S_IDLE);
			S_L1:   w = uw(U_NOP,       RA_NONE, CA_AM1,  C_A_ZERO,   S_L3);
			S_L2:   w = uw(U_LD_SHIFT,  RA_NONE, CA_NONE, C_CH_GT,    S_L1);
			S_L3:   w = uw(U_LD_PUT,    RA_NONE, CA_NONE, C_JUMP,     S_IDLE);
			// pivot search from the right
			S_E0:   w = uw(U_EM_INIT,   RA_NONE, CA_NONE, C_LEN_ZERO, S_IDLE);
			S_E1:   w = uw(U_NOP,       RA_A,    CA_NONE, C_NEXT,     S_IDLE);
			S_E2:   w = uw(U_SAVE_B,    RA_NONE, CA_NONE, C_A_ZERO,   S_O0);
			S_E3:   w = uw(U_DEC_A,     RA_NONE, CA_NONE, C_NEXT,     S_IDLE);
			S_E4:   w = uw(U_NOP,       RA_A,    CA_NONE, C_NEXT,     S_IDLE);
			S_E5:   w = uw(U_PIV_TEST,  RA_NONE, CA_NONE, C_RD_LT_B,  S_O0);
			S_E6:   w = uw(U_NOP,       RA_NONE, CA_NONE, C_A_NZ,     S_E3);
			// send out the arrangement
			S_O0:   w = uw(U_OUT_INIT,  RA_NONE, CA_NONE, C_NEXT,     S_IDLE);
			S_O1:   w = uw(U_NOP,       RA_A,    CA_NONE, C_NEXT,     S_IDLE);
			S_O2:   w = uw(U_NOP,       RA_NONE, CA_POS,  C_NEXT,     S_IDLE);
			S_O3:   w = uw(U_EMIT,      RA_NONE, CA_NONE, C_A_NLAST,  S_O1);
			// rightmost larger element and swap
			S_A0:   w = uw(U_ADV_INIT,  RA_NONE, CA_NONE, C_FIN,      S_IDLE);
			S_A1:   w = uw(U_NOP,       RA_B,    CA_NONE, C_NEXT,     S_IDLE);
			S_A2:   w = uw(U_SCAN_B,    RA_NONE, CA_NONE, C_RD_LE_A,  S_A1);
			S_A3:   w = uw(U_SWAP_P,    RA_NONE, CA_NONE, C_NEXT,     S_IDLE);
			S_A4:   w = uw(U_SWAP_J,    RA_NONE, CA_NONE, C_NEXT,     S_IDLE);
			// suffix is descending: reverse it
			S_R0:   w = uw(U_NOP,       RA_NONE, CA_NONE, C_A_GE_B,   S_IDLE);
			S_R1:   w = uw(U_NOP,       RA_A,    CA_NONE, C_NEXT,     S_IDLE);
			S_R2:   w = uw(U_SAVE_A,    RA_B,    CA_NONE, C_NEXT,     S_IDLE);
			S_R3:   w = uw(U_WR_A,      RA_NONE, CA_NONE, C_NEXT,     S_IDLE);
			S_R4:   w = uw(U_WR_B_STEP, RA_NONE, CA_NONE, C_JUMP,     S_R0);
			default: w = uw(U_NOP,      RA_NONE, CA_NONE, C_JUMP,     S_IDLE);
		endcase
		return w;
	endfunction

	// program entry per command
	function automatic logic [UPC_W-1:0] start_step(input cmd_t cmd);
		logic [UPC_W-1:0] s;
		case (cmd)
			CMD_CLEAR: s = S_CLR;
			CMD_LOAD:  s = S_L0;
			CMD_EMIT:  s = S_E0;
			default:   s = S_IDLE;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lexicographic_permutation_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                         | transfer when
// --------+---------------------------------+-----------------------
// request | req_valid, req_ready, req_data  | req_valid & req_ready
// result  | rsp_valid, rsp_ready, rsp_data  | rsp_valid & rsp_ready
//
// one request at a time, a microprogram step per cycle but while the output step is held,
// one port per store; clear empties the string; load does a sorted insert, moving larger
// stored characters up one place, and takes nothing when full; emit of n finds the pivot
// from the right, sends the n characters out, then, unless final, swaps the pivot with
// the rightmost larger entry and reverses the suffix
// reset clears length, valid bits, sequencer; a full result register holds the output step
module lexicographic_permutation_generator_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  lpg_pkg::req_t    req_data,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output lpg_pkg::rsp_t    rsp_data
);
	import lpg_pkg::*;

	// sequencer
	logic [UPC_W-1:0] upc_q;
	ucode_t           cw;
	logic             hold;
	uop_t             op;
	logic             cond_hit;

	// datapath registers
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_a_q;
	logic [LEN_W-1:0]  idx_b_q;
	logic [IDX_W-1:0]  piv_q;
	logic [IDX_W-1:0]  va_q;
	logic [IDX_W-1:0]  vb_q;
	logic              fin_q;
	logic [CHAR_W-1:0] ch_q;

	// stores
	logic [CHAR_W-1:0] ch_mem [MAX_LEN];
	logic [IDX_W-1:0]  pos_mem [MAX_LEN];
	logic [MAX_LEN-1:0] pos_vld_q;
	logic [CHAR_W-1:0] ch_rd_q;
	logic [IDX_W-1:0]  pos_rd_q;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// store ports
	logic              ch_re;
	logic [IDX_W-1:0]  ch_ra;
	logic              ch_we;
	logic [IDX_W-1:0]  ch_wa;
	logic [CHAR_W-1:0] ch_wd;
	logic              pos_re;
	logic [IDX_W-1:0]  pos_ra;
	logic              pos_we;
	logic [IDX_W-1:0]  pos_wa;
	logic [IDX_W-1:0]  pos_wd;
	logic              vld_clr;

	// flags
	logic [LEN_W-1:0] len_m1;
	logic a_zero, a_last, ch_gt, rd_lt_b, rd_le_a, a_ge_b, full;

	assign cw   = ucode_rom(upc_q);
	assign hold = (cw.op == U_EMIT) && rsp_valid_q && !rsp_ready;
	assign op   = hold ? U_NOP : cw.op;

	assign req_ready = (upc_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign len_m1  = len_q - LEN_W'(1);
	assign a_zero  = (idx_a_q == '0);
	assign a_last  = (idx_a_q == len_m1);
	assign ch_gt   = (ch_rd_q > ch_q);
	assign rd_lt_b = (pos_rd_q < vb_q);
	assign rd_le_a = (pos_rd_q <= va_q);
	assign a_ge_b  = (idx_a_q >= idx_b_q);
	assign full    = (len_q == LEN_W'(MAX_LEN));

	// branch condition select
	always_comb begin
		case (cw.cond)
			C_NEXT:     cond_hit = 1'b0;
			C_JUMP:     cond_hit = 1'b1;
			C_FULL:     cond_hit = full;
			C_A_ZERO:   cond_hit = a_zero;
			C_A_NZ:     cond_hit = !a_zero;
			C_CH_GT:    cond_hit = ch_gt;
			C_LEN_ZERO: cond_hit = (len_q == '0);
			C_RD_LT_B:  cond_hit = rd_lt_b;
			C_A_NLAST:  cond_hit = !a_last;
			C_FIN:      cond_hit = fin_q;
			C_RD_LE_A:  cond_hit = rd_le_a;
			C_A_GE_B:   cond_hit = a_ge_b;
			default:    cond_hit = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else if (upc_q == S_IDLE) begin
			if (req_valid) begin
				upc_q <= start_step(req_data.command);
			end
		end else if (!hold) begin
			upc_q <= cond_hit ? cw.target : upc_q + UPC_W'(1);
		end
	end

	// read address selects
	always_comb begin
		pos_re = (cw.pos_ra != RA_NONE);
		pos_ra = (cw.pos_ra == RA_B) ? idx_b_q[IDX_W-1:0] : idx_a_q[IDX_W-1:0];
		ch_re  = (cw.ch_ra != CA_NONE);
		ch_ra  = (cw.ch_ra == CA_POS) ? pos_rd_q : (idx_a_q[IDX_W-1:0] - IDX_W'(1));
	end

	// write port decode
	always_comb begin
		ch_we   = 1'b0;
		ch_wa   = idx_a_q[IDX_W-1:0];
		ch_wd   = ch_q;
		pos_we  = 1'b0;
		pos_wa  = idx_a_q[IDX_W-1:0];
		pos_wd  = pos_rd_q;
		vld_clr = 1'b0;
		case (op)
			U_CLEAR: begin
				vld_clr = 1'b1;
			end
			U_LD_SHIFT: begin
				ch_we = ch_gt;
				ch_wd = ch_rd_q;
			end
			U_LD_PUT: begin
				ch_we   = 1'b1;
				vld_clr = 1'b1;
			end
			U_SWAP_P: begin
				pos_we = 1'b1;
				pos_wa = piv_q;
				pos_wd = vb_q;
			end
			U_SWAP_J: begin
				pos_we = 1'b1;
				pos_wa = idx_b_q[IDX_W-1:0];
				pos_wd = va_q;
			end
			U_WR_A: begin
				pos_we = 1'b1;
			end
			U_WR_B_STEP: begin
				pos_we = 1'b1;
				pos_wa = idx_b_q[IDX_W-1:0];
				pos_wd = va_q;
			end
			default: begin
			end
		endcase
	end

	// character store
	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch_mem[ch_wa] <= ch_wd;
		end
		if (ch_re) begin
			ch_rd_q <= ch_mem[ch_ra];
		end
	end

	// position store, unwritten entries read as identity
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		if (pos_re) begin
			pos_rd_q <= pos_vld_q[pos_ra] ? pos_mem[pos_ra] : pos_ra;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (vld_clr) begin
				pos_vld_q <= '0;
			end else if (pos_we) begin
				pos_vld_q[pos_wa] <= 1'b1;
			end
			if (op == U_CLEAR) begin
				len_q <= '0;
			end else if (op == U_LD_PUT) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (op == U_EMIT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture and work registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ch_q <= req_data.char_in;
		end
		case (op)
			U_LD_INIT: begin
				idx_a_q <= len_q;
			end
			U_LD_SHIFT: begin
				if (ch_gt) begin
					idx_a_q <= idx_a_q - LEN_W'(1);
				end
			end
			U_EM_INIT: begin
				idx_a_q <= len_m1;
				fin_q   <= 1'b1;
			end
			U_SAVE_B: begin
				vb_q <= pos_rd_q;
			end
			U_DEC_A: begin
				idx_a_q <= idx_a_q - LEN_W'(1);
			end
			U_PIV_TEST: begin
				vb_q <= pos_rd_q;
				if (rd_lt_b) begin
					fin_q <= 1'b0;
					piv_q <= idx_a_q[IDX_W-1:0];
					va_q  <= pos_rd_q;
				end
			end
			U_OUT_INIT: begin
				idx_a_q <= '0;
			end
			U_EMIT: begin
				rsp_q.char_out          <= ch_rd_q;
				rsp_q.last_char         <= a_last;
				rsp_q.final_arrangement <= fin_q;
				idx_a_q                 <= idx_a_q + LEN_W'(1);
			end
			U_ADV_INIT: begin
				idx_b_q <= len_m1;
			end
			U_SCAN_B: begin
				if (rd_le_a) begin
					idx_b_q <= idx_b_q - LEN_W'(1);
				end else begin
					vb_q <= pos_rd_q;
				end
			end
			U_SWAP_J: begin
				idx_a_q <= LEN_W'(piv_q) + LEN_W'(1);
				idx_b_q <= len_m1;
			end
			U_SAVE_A: begin
				va_q <= pos_rd_q;
			end
			U_WR_B_STEP: begin
				idx_a_q <= idx_a_q + LEN_W'(1);
				idx_b_q <= idx_b_q - LEN_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/lpg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpg_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_ready,
	input lpg_pkg::req_t req_data,
	input wire           rsp_valid,
	input wire           rsp_ready,
	input lpg_pkg::rsp_t rsp_data
);
	import lpg_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// every real command leaves the request side closed in the cycle after its transfer
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.command != CMD_RSVD |=> !req_ready)
		else $error("request side ready right after a command transfer");

	// the unused command leaves the block idle
	a_rsvd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.command == CMD_RSVD |=> req_ready)
		else $error("unused command started a program");

	// an arrangement still being sent keeps the request side closed
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last_char |-> !req_ready)
		else $error("request side open in the middle of an arrangement");

endmodule

bind lexicographic_permutation_generator_core lpg_checker u_lpg_checker (.*);
`default_nettype wire

// ===== sim/lpg_arrangement_checker.sv =====
`timescale 1ns / 1ps
module lpg_arrangement_checker (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	input  wire           req_ready,
	input  lpg_pkg::req_t req_data,
	input  wire           rsp_valid,
	input  wire           rsp_ready,
	input  lpg_pkg::rsp_t rsp_data,
	output int            mismatches,
	output int            chars_pending,
	output int            chars_seen,
	output int            final_emits
);
	import lpg_pkg::*;

	// shadow of the block: sorted characters, position order, length
	logic [CHAR_W-1:0] char_store [MAX_LEN];
	logic [IDX_W-1:0]  perm_order [MAX_LEN];
	int                char_count;
	rsp_t              expected_chars [$];

	int fail_count;
	int result_count;
	int final_count;

	function automatic void reset_order();
		for (int i = 0; i < MAX_LEN; i++) perm_order[i] = IDX_W'(i);
	endfunction

	// next lexicographic order of the first char_count positions
	function automatic void next_order();
		int               p;
		int               j;
		int               lo;
		int               hi;
		logic [IDX_W-1:0] t;
		p = char_count - 2;
		while (p >= 0 && perm_order[p] > perm_order[p + 1]) p--;
		if (p >= 0) begin
			j = char_count - 1;
			while (!(perm_order[j] > perm_order[p])) j--;
			t             = perm_order[p];
			perm_order[p] = perm_order[j];
			perm_order[j] = t;
			// suffix is descending after the swap: reversing sorts it
			lo = p + 1;
			hi = char_count - 1;
			while (lo < hi) begin
				t              = perm_order[lo];
				perm_order[lo] = perm_order[hi];
				perm_order[hi] = t;
				lo++;
				hi--;
			end
		end
	endfunction

	// apply one accepted request to the shadow and queue its characters
	task automatic run_command(input req_t r);
		int   i;
		bit   is_last;
		rsp_t c;
		case (r.command)
			CMD_CLEAR: begin
				char_count = 0;
				reset_order();
			end
			CMD_LOAD: begin
				if (char_count < MAX_LEN) begin
					i = char_count;
					while (i > 0 && char_store[i - 1] > r.char_in) begin
						char_store[i] = char_store[i - 1];
						i--;
					end
					char_store[i] = r.char_in;
					char_count++;
					reset_order();
				end
			end
			CMD_EMIT: begin
				if (char_count != 0) begin
					is_last = 1'b1;
					for (i = 1; i < char_count; i++)
						if (perm_order[i - 1] < perm_order[i]) is_last = 1'b0;
					for (i = 0; i < char_count; i++) begin
						c.char_out          = char_store[perm_order[i]];
						c.last_char         = (i == char_count - 1);
						c.final_arrangement = is_last;
						expected_chars.insert(expected_chars.size(), c);
					end
					if (!is_last) next_order();
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic void report_field(input string field, input int want, input int got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endfunction

	// compare result transfers, then predict from request transfers
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			char_count = 0;
			reset_order();
			expected_chars.delete();
			fail_count   = 0;
			result_count = 0;
			final_count  = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				result_count++;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
						$time, rsp_data.char_out, rsp_data.last_char,
						rsp_data.final_arrangement);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (rsp_data.char_out !== want.char_out)
						report_field("char_out", want.char_out, rsp_data.char_out);
					if (rsp_data.last_char !== want.last_char)
						report_field("last_char", want.last_char, rsp_data.last_char);
					if (rsp_data.final_arrangement !== want.final_arrangement)
						report_field("final_arrangement", want.final_arrangement,
							rsp_data.final_arrangement);
					if (want.last_char && want.final_arrangement) final_count++;
				end
			end
			if (req_valid && req_ready) run_command(req_data);
		end
		mismatches    <= fail_count;
		chars_pending <= expected_chars.size();
		chars_seen    <= result_count;
		final_emits   <= final_count;
	end

endmodule

// ===== sim/lexicographic_permutation_generator_core_tb.sv =====
`timescale 1ns / 1ps
module lexicographic_permutation_generator_core_tb;
	import lpg_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 200;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_go;
	bit hold_done;
	int idle_cycles;
	int counted_items;

	int mismatches;
	int chars_pending;
	int chars_seen;
	int final_emits;

	lexicographic_permutation_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	lpg_arrangement_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_data      (req_data),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp_data      (rsp_data),
		.mismatches    (mismatches),
		.chars_pending (chars_pending),
		.chars_seen    (chars_seen),
		.final_emits   (final_emits)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				rsp_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// no transfer on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("lexicographic_permutation_generator_core_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// offer one request, with random gaps before it, until it is taken
	task automatic issue(input cmd_t cmd, input logic [CHAR_W-1:0] ch);
		req_t r;
		r.command = cmd;
		r.char_in = ch;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		counted_items++;
	endtask

	function automatic logic [CHAR_W-1:0] any_char();
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// mostly a clear, a word and a run of emits; some stray requests
	task automatic random_word();
		int  kind;
		int  len;
		int  emits;
		bit  narrow;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) len = $urandom_range(1, 4);
			else if (kind < 9) len = $urandom_range(5, 7);
			else len = MAX_LEN;
			narrow = ($urandom_range(0, 2) == 0);
			issue(CMD_CLEAR, any_char());
			for (int k = 0; k < len; k++)
				issue(CMD_LOAD, narrow ? CHAR_W'($urandom_range(8'h41, 8'h43)) : any_char());
			// short words often run through every order and past the last one
			if (len <= 4 && $urandom_range(0, 1) == 1) begin
				emits = 1;
				for (int k = 2; k <= len; k++) emits *= k;
				emits += $urandom_range(0, 2);
			end else begin
				emits = $urandom_range(1, 8);
			end
			for (int k = 0; k < emits; k++) issue(CMD_EMIT, any_char());
		end else begin
			case ($urandom_range(0, 3))
				0: issue(CMD_RSVD, any_char());
				1: issue(CMD_LOAD, any_char());
				2: issue(CMD_EMIT, any_char());
				default: issue(CMD_CLEAR, any_char());
			endcase
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		hold_go       = 1'b0;
		idle_cycles   = 0;
		counted_items = 0;
		send_idle_pct = 32;
		recv_idle_pct = 66;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string and the unused command
		issue(CMD_EMIT, 8'h00);
		issue(CMD_RSVD, 8'hFF);
		// single character, emitted twice
		issue(CMD_LOAD, 8'hFF);
		issue(CMD_EMIT, 8'h00);
		issue(CMD_EMIT, 8'hFF);
		// three characters through all six orders and one more
		issue(CMD_CLEAR, 8'hFF);
		issue(CMD_LOAD, 8'h00);
		issue(CMD_LOAD, 8'hFF);
		issue(CMD_LOAD, 8'h80);
		for (int k = 0; k < 7; k++) issue(CMD_EMIT, 8'h00);
		// fill up with repeats, then one load too many
		issue(CMD_LOAD, 8'h80);
		issue(CMD_LOAD, 8'h01);
		issue(CMD_LOAD, 8'hFE);
		issue(CMD_LOAD, 8'h7F);
		issue(CMD_LOAD, 8'h80);
		issue(CMD_LOAD, 8'h55);
		issue(CMD_EMIT, 8'hAA);
		issue(CMD_EMIT, 8'h55);

		while (counted_items < 140) random_word();

		send_idle_pct = 66;
		recv_idle_pct = 32;
		while (counted_items < 250) random_word();

		// no idling; long result hold-off while full words keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go       = 1'b1;
		issue(CMD_CLEAR, 8'h00);
		for (int k = 0; k < MAX_LEN; k++) issue(CMD_LOAD, any_char());
		for (int k = 0; k < 6; k++) issue(CMD_EMIT, any_char());
		while (counted_items < 370) random_word();
		req_valid <= 1'b0;

		while (chars_pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d requests (clear, load, emit and stray ones), %0d characters out,",
			counted_items, chars_seen);
		$display("%0d emits of a last order, and a %0d-cycle result hold-off",
			final_emits, HOLD_CYCLES);
		if (mismatches == 0 && chars_pending == 0)
			$display("lexicographic_permutation_generator_core_tb OK");
		else
			$display("lexicographic_permutation_generator_core_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lpg_pkg.sv
hdl/lexicographic_permutation_generator_core.sv
hdl/lpg_checker.sv
sim/lpg_arrangement_checker.sv
sim/lexicographic_permutation_generator_core_tb.sv
